### rtl/itoa_pkg.sv
package itoa_pkg;

   localparam int MaxField = 63;

   localparam logic [1:0] OP_SDEC = 2'd0;
   localparam logic [1:0] OP_UDEC = 2'd1;
   localparam logic [1:0] OP_CHAR = 2'd2;
   localparam logic [1:0] OP_PTR  = 2'd3;

   localparam logic [2:0] DUMP_NONE    = 3'd0;
   localparam logic [2:0] DUMP_BITS_LE = 3'd1;
   localparam logic [2:0] DUMP_HEX_LE  = 3'd2;
   localparam logic [2:0] DUMP_BITS_BE = 3'd3;
   localparam logic [2:0] DUMP_HEX_BE  = 3'd4;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_X     = 8'h78;

   // emission segments, in output order
   typedef enum logic [2:0] {
      SEG_LPAD,
      SEG_PREFIX,
      SEG_ZEROS,
      SEG_BODY,
      SEG_RPAD
   } seg_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic emit_done;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib >= 4'd10) r = 8'h61 + {4'd0, nib} - 8'd10;
      else r = CH_ZERO + {4'd0, nib};
      return r;
   endfunction

endpackage

### rtl/itoa_ctrl.sv
module itoa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output itoa_pkg::cmd_type     cmd,
   input  itoa_pkg::status_type  status
);
   import itoa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.conv_step  = 1'b0;
      cmd.emit       = 1'b0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

### rtl/itoa_dp.sv
module itoa_dp #(
   parameter int MAX_FIELD = itoa_pkg::MaxField
) (
   input  logic                  clock,
   input  logic                  reset,
   input  itoa_pkg::cmd_type     cmd,
   output itoa_pkg::status_type  status,
   input  logic [1:0]            req_op,
   input  logic [63:0]           req_value,
   input  logic [2:0]            req_dump_mode,
   input  logic                  req_left_justify,
   input  logic                  req_has_width,
   input  logic [5:0]            req_field_width,
   input  logic                  req_has_precision,
   input  logic [5:0]            req_min_digits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);
   import itoa_pkg::*;

   localparam logic [5:0] MaxF = 6'(MAX_FIELD);

   // latched request
   logic [1:0]  op_ff;
   logic [63:0] val_ff;
   logic [2:0]  mode_ff;
   logic        left_ff;
   logic [5:0]  wid_ff, prec_ff;
   // decimal digits, stored least significant first
   logic [31:0] quo_ff;
   logic [3:0]  dig_ff [10];
   logic [3:0]  ndig_ff;
   logic        neg_ff;
   // emission
   seg_type     seg_ff;
   logic [5:0]  cnt_ff;
   logic [5:0]  nz_ff, nsp_ff;
   logic [5:0]  blen_ff;
   logic        busy_ff;

   logic [31:0] q10;
   logic [3:0]  r10;
   logic [35:0] prod;
   logic [5:0]  w_sat, p_sat;
   logic [2:0]  mode_eff;
   logic [5:0]  zeros, spaces, bodylen, tot;
   logic [4:0]  pdig;
   logic [7:0]  bodych;
   logic [7:0]  outch;
   logic        seg_last, all_last;
   logic [1:0]  bsel;
   logic [7:0]  sbyte;
   logic [5:0]  bidx;
   logic [2:0]  bpos;
   logic [3:0]  didx;
   logic        pad_l, pad_r;

   // divide by 10 via reciprocal multiply
   assign prod = 36'(({32'd0, quo_ff} * 64'hCCCCCCCD) >> 35);
   assign q10  = prod[31:0];
   assign r10  = 4'(quo_ff - 32'(q10 * 32'd10));

   assign w_sat    = (req_field_width > MaxF) ? MaxF : req_field_width;
   assign p_sat    = (req_min_digits > MaxF) ? MaxF : req_min_digits;
   assign mode_eff = (req_dump_mode > DUMP_HEX_BE) ? DUMP_NONE : req_dump_mode;

   // pointer hex digit count
   always_comb begin
      pdig = 5'd1;
      for (int i = 1; i < 16; i++)
         if (val_ff[4*i +: 4] != 4'd0) pdig = 5'(i + 1);
   end

   always_comb begin
      zeros  = 6'd0;
      spaces = 6'd0;
      if (prec_ff > {2'd0, ndig_ff}) zeros = prec_ff - {2'd0, ndig_ff};
      tot = zeros + {2'd0, ndig_ff};
      if (wid_ff > tot) spaces = wid_ff - tot;
      if (op_ff == OP_PTR) bodylen = {1'b0, pdig};
      else if (mode_ff != DUMP_NONE) begin
         if (mode_ff == DUMP_BITS_LE || mode_ff == DUMP_BITS_BE)
            bodylen = (op_ff == OP_CHAR) ? 6'd8 : 6'd35;
         else bodylen = (op_ff == OP_CHAR) ? 6'd2 : 6'd11;
      end else if (op_ff == OP_CHAR) bodylen = 6'd1;
      else bodylen = {2'd0, ndig_ff};
   end

   // body character generation
   always_comb begin
      bidx  = 6'd0;
      bpos  = 3'd0;
      bsel  = 2'd0;
      didx  = 4'd0;
      sbyte = 8'd0;
      bodych = CH_ZERO;
      if (op_ff == OP_PTR) begin
         bodych = hex_char(val_ff[4*(blen_ff - 6'd1 - cnt_ff) +: 4]);
      end else if (mode_ff != DUMP_NONE) begin
         if (mode_ff == DUMP_BITS_LE || mode_ff == DUMP_BITS_BE) begin
            bidx = (cnt_ff >= 6'd27) ? 6'd3 : (cnt_ff >= 6'd18) ? 6'd2 :
                   (cnt_ff >= 6'd9) ? 6'd1 : 6'd0;
            bpos = 3'(cnt_ff - 6'(bidx * 6'd9));
            if (cnt_ff - 6'(bidx * 6'd9) == 6'd8) bodych = CH_SPACE;
            else begin
               bsel = (mode_ff == DUMP_BITS_BE) ? 2'(3 - bidx) : bidx[1:0];
               if (op_ff == OP_CHAR) bsel = 2'd0;
               sbyte = val_ff[8*bsel +: 8];
               bodych = CH_ZERO + {7'd0, sbyte[3'd7 - bpos]};
            end
         end else begin
            bidx = (cnt_ff >= 6'd9) ? 6'd3 : (cnt_ff >= 6'd6) ? 6'd2 :
                   (cnt_ff >= 6'd3) ? 6'd1 : 6'd0;
            bpos = 3'(cnt_ff - 6'(bidx * 6'd3));
            if (bpos == 3'd2) bodych = CH_SPACE;
            else begin
               bsel = (mode_ff == DUMP_HEX_BE) ? 2'(3 - bidx) : bidx[1:0];
               if (op_ff == OP_CHAR) bsel = 2'd0;
               sbyte = val_ff[8*bsel +: 8];
               bodych = hex_char(bpos[0] ? sbyte[3:0] : sbyte[7:4]);
            end
         end
      end else if (op_ff == OP_CHAR) bodych = val_ff[7:0];
      else begin
         didx = 4'(blen_ff - 6'd1 - cnt_ff);
         bodych = CH_ZERO + {4'd0, dig_ff[didx]};
      end
   end

   assign pad_l = (op_ff == OP_UDEC) && (mode_ff == DUMP_NONE) && !left_ff;
   assign pad_r = (op_ff == OP_UDEC) && (mode_ff == DUMP_NONE) && left_ff;

   always_comb begin
      outch    = CH_SPACE;
      seg_last = 1'b0;
      all_last = 1'b0;
      case (seg_ff)
         SEG_LPAD: begin
            outch = CH_SPACE;
            seg_last = (cnt_ff + 6'd1 == nsp_ff);
         end
         SEG_PREFIX: begin
            if (op_ff == OP_PTR) outch = (cnt_ff == 6'd0) ? CH_ZERO : CH_X;
            else outch = CH_MINUS;
            seg_last = (op_ff == OP_PTR) ? (cnt_ff == 6'd1) : 1'b1;
         end
         SEG_ZEROS: begin
            outch = CH_ZERO;
            seg_last = (cnt_ff + 6'd1 == nz_ff);
         end
         SEG_BODY: begin
            outch = bodych;
            seg_last = (cnt_ff + 6'd1 == blen_ff);
            all_last = seg_last && !(pad_r && nsp_ff != 6'd0);
         end
         SEG_RPAD: begin
            outch = CH_SPACE;
            seg_last = (cnt_ff + 6'd1 == nsp_ff);
            all_last = seg_last;
         end
         default: ;
      endcase
   end

   assign status.conv_done = busy_ff && (quo_ff == 32'd0);
   assign status.emit_done = rsp_valid && !rsp_stall && rsp_last;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         val_ff  <= req_value;
         mode_ff <= mode_eff;
         left_ff <= req_left_justify;
         wid_ff  <= req_has_width ? w_sat : 6'd0;
         prec_ff <= req_has_precision ? p_sat : 6'd0;
         neg_ff  <= (req_op == OP_SDEC) && req_value[31];
         quo_ff  <= (req_op == OP_SDEC && req_value[31]) ? 32'(-req_value[31:0])
                                                         : req_value[31:0];
         ndig_ff <= 4'd0;
      end else if (cmd.conv_step && quo_ff != 32'd0) begin
         dig_ff[ndig_ff] <= r10;
         ndig_ff <= ndig_ff + 4'd1;
         quo_ff  <= q10;
      end else if (cmd.conv_step) begin
         if (ndig_ff == 4'd0) begin
            dig_ff[0] <= 4'd0;
            ndig_ff   <= 4'd1;
         end
      end
   end

   // busy_ff is registered and gates conv_done so the zero-digit fixup lands first
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= cmd.conv_step && !status.conv_done;
   end

   logic emit_go;
   assign emit_go = cmd.emit && (!rsp_valid || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         seg_ff    <= SEG_LPAD;
         cnt_ff    <= 6'd0;
      end else begin
         if (cmd.conv_step && status.conv_done) begin
            nz_ff   <= zeros;
            nsp_ff  <= spaces;
            blen_ff <= bodylen;
            cnt_ff  <= 6'd0;
            if (pad_l && spaces != 6'd0) seg_ff <= SEG_LPAD;
            else if (op_ff == OP_PTR || (neg_ff && mode_ff == DUMP_NONE))
               seg_ff <= SEG_PREFIX;
            else if (pad_l || pad_r) seg_ff <= (zeros != 6'd0) ? SEG_ZEROS : SEG_BODY;
            else seg_ff <= SEG_BODY;
         end else if (emit_go && !(rsp_valid && rsp_last)) begin
            rsp_valid     <= 1'b1;
            rsp_character <= outch;
            rsp_last      <= all_last;
            cnt_ff        <= seg_last ? 6'd0 : cnt_ff + 6'd1;
            if (seg_last) begin
               case (seg_ff) inside
                  SEG_LPAD, SEG_PREFIX:
                     seg_ff <= (nz_ff != 6'd0 && seg_ff == SEG_LPAD) ? SEG_ZEROS : SEG_BODY;
                  SEG_ZEROS: seg_ff <= SEG_BODY;
                  default:   seg_ff <= SEG_RPAD;
               endcase
            end
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule

### rtl/integer_to_ascii_formatter.sv
// Converts one integer request into ASCII characters, one result beat per character with
// rsp_last on the final one. A request is latched, converted digit by digit (at most ten
// decimal digits) through the divide-by-ten unit plus a closing step, then emitted
// character by character, at most 63 for a padded unsigned value; the next request is taken
// once the last character beat has been accepted.
module integer_to_ascii_formatter #(
   parameter int MAX_FIELD = itoa_pkg::MaxField
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_value,
   input  logic [2:0]  req_dump_mode,
   input  logic        req_left_justify,
   input  logic        req_has_width,
   input  logic [5:0]  req_field_width,
   input  logic        req_has_precision,
   input  logic [5:0]  req_min_digits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);
   import itoa_pkg::*;

   cmd_type    cmd;
   status_type status;

   itoa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .cmd, .status
   );

   itoa_dp #(.MAX_FIELD(MAX_FIELD)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_op, .req_value, .req_dump_mode, .req_left_justify, .req_has_width,
      .req_field_width, .req_has_precision, .req_min_digits,
      .rsp_valid, .rsp_stall, .rsp_character, .rsp_last
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character))
      else $error("stalled beat changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during emission");

endmodule
